@@ design/assert_macros.svh @@
// assertion macros shared by the tally design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define CCT_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/cct_pkg.sv @@
// shared constants and types of the coupon collector tally
`default_nettype none

package cct_pkg;

    localparam int TALLY_BINS_DEF  = 4096;
    localparam int MAX_COUPONS_DEF = 12;

    localparam int CC_W    = 4;
    localparam int COUNT_W = 32;
    localparam int LEN_W   = 12;
    localparam int BIN_W   = 12;
    localparam int SAMPLE_W = 32;

    localparam logic [CC_W-1:0] CC_RESET = 4'd2;
    localparam logic [CC_W-1:0] CC_MIN   = 4'd2;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

endpackage

`default_nettype wire

@@ design/coupon_collector_tally_top.sv @@
// top level of the coupon collector tally
// throughput: one beat per cycle in each direction while m_ready is high and no sweep runs
// an accepted beat reaches m_valid through the input register, the histogram read
//   register and the result register
// reset: synchronous active-low; afterwards the histogram is swept to zero,
//   one bin per cycle, with s_ready low until the sweep ends; cfg writes still taken
`default_nettype none
`include "assert_macros.svh"

module coupon_collector_tally_top
    import cct_pkg::*;
#(
    parameter int TALLY_BINS  = TALLY_BINS_DEF,
    parameter int MAX_COUPONS = MAX_COUPONS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_wr_en,
    input  wire logic [CC_W-1:0]     cfg_wr_data,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic [SAMPLE_W-1:0] s_sample,
    input  wire logic [BIN_W-1:0]    s_bin_index,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_tuple_done,
    output logic      [LEN_W-1:0]    m_tuple_length,
    output logic      [COUNT_W-1:0]  m_tally_count,
    output logic      [LEN_W-1:0]    m_max_length
);

    localparam int AW = $clog2(TALLY_BINS);

    // stage 1: captured input beat
    logic                v1_reg;
    kind_t               kind1_reg;
    logic [SAMPLE_W-1:0] sample1_reg;
    logic [BIN_W-1:0]    bin1_reg;

    // stage 2: tuple result, waiting on the histogram read
    logic                v2_reg;
    kind_t               kind2_reg;
    logic                inrange2_reg;
    logic                done2_reg;
    logic [AW-1:0]       len2_reg;
    logic [AW-1:0]       longest2_reg;

    // result register
    logic                out_v_reg;
    logic                done_out_reg;
    logic [LEN_W-1:0]    len_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [LEN_W-1:0]    max_out_reg;

    // per-stage advance, a stage moves when the one after it has room
    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic s1_move;

    logic               tuple_step;
    logic               done1;
    logic [AW-1:0]      len1;
    logic [AW-1:0]      longest1;
    logic               inrange1;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_go;
    logic [COUNT_W-1:0] rd_count;
    logic               clr_busy;

    // terms for the checks below
    logic done_beat;
    logic len_ok;
    logic count_beat;
    logic write_ok;

    assign out_adv = !out_v_reg || m_ready;
    assign s2_adv  = !v2_reg || out_adv;
    assign s1_adv  = !v1_reg || s2_adv;
    assign s1_move = v1_reg && s2_adv;
    assign s_ready = !clr_busy && s1_adv;

    // sample beats step the tuple tracker as they leave stage 1
    assign tuple_step = s1_move && (kind1_reg == KIND_SAMPLE);

    cct_tuple #(
        .TALLY_BINS  (TALLY_BINS),
        .MAX_COUPONS (MAX_COUPONS)
    ) u_tuple (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .step         (tuple_step),
        .sample       (sample1_reg),
        .done         (done1),
        .len          (len1),
        .longest_next (longest1)
    );

    // bins beyond the histogram read back as zero
    assign inrange1 = 32'(bin1_reg) < TALLY_BINS;

    // read the requested bin, or the bin that a finished tuple bumps
    assign rd_addr = (kind1_reg == KIND_READ) ? AW'(bin1_reg) : len1;
    assign rd_en   = s1_move && ((kind1_reg == KIND_READ) || done1);

    // the increment is written as the finished tuple leaves stage 2
    assign wr_go = v2_reg && out_adv && (kind2_reg == KIND_SAMPLE) && done2_reg;

    cct_tally #(
        .TALLY_BINS (TALLY_BINS)
    ) u_tally (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_go    (wr_go),
        .rd_count (rd_count),
        .busy     (clr_busy)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                v1_reg <= s_valid && s_ready;
            end
            if (s2_adv) begin
                v2_reg <= v1_reg;
            end
            if (out_adv) begin
                out_v_reg <= v2_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind1_reg   <= kind_t'(s_kind);
            sample1_reg <= s_sample;
            bin1_reg    <= s_bin_index;
        end
        if (s1_move) begin
            kind2_reg    <= kind1_reg;
            inrange2_reg <= inrange1;
            done2_reg    <= (kind1_reg == KIND_SAMPLE) && done1;
            len2_reg     <= (kind1_reg == KIND_SAMPLE) ? len1 : '0;
            longest2_reg <= longest1;
        end
        if (out_adv && v2_reg) begin
            done_out_reg  <= done2_reg;
            len_out_reg   <= LEN_W'(len2_reg);
            count_out_reg <= ((kind2_reg == KIND_READ) && inrange2_reg) ? rd_count : '0;
            max_out_reg   <= LEN_W'(longest2_reg);
        end
    end

    assign m_valid        = out_v_reg;
    assign m_tuple_done   = done_out_reg;
    assign m_tuple_length = len_out_reg;
    assign m_tally_count  = count_out_reg;
    assign m_max_length   = max_out_reg;

    assign done_beat  = m_valid && m_tuple_done;
    assign len_ok     = (m_tuple_length != '0) && (m_max_length >= m_tuple_length);
    assign count_beat = m_valid && (m_tally_count != '0);
    assign write_ok   = v2_reg && done2_reg && !clr_busy;

    // a finished tuple has a nonzero length no longer than the running maximum
    `CCT_ASSERT(a_done_len, aclk, aresetn, done_beat |-> len_ok, "tuple length inconsistent")
    // a read beat with a nonzero count never reports a finished tuple
    `CCT_ASSERT(a_read_not_done, aclk, aresetn, count_beat |-> !m_tuple_done, "read flagged done")
    // nothing is taken in the cycle after reset, the sweep is running
    `CCT_ASSERT_ANY(a_sweep_blocks, aclk, !aresetn |=> !s_ready, "input taken during sweep")
    // a bin write only happens when a finished tuple leaves stage 2
    `CCT_ASSERT(a_write_src, aclk, aresetn, wr_go |-> write_ok, "stray histogram write")

endmodule

`default_nettype wire

@@ design/cct_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module cct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/cct_tuple.sv @@
// coupon draw, seen bitmap, run length and longest length
`default_nettype none

module cct_tuple
    import cct_pkg::*;
#(
    parameter int TALLY_BINS  = TALLY_BINS_DEF,
    parameter int MAX_COUPONS = MAX_COUPONS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CC_W-1:0]               cfg_wr_data,
    input  wire logic                          step,
    input  wire logic [SAMPLE_W-1:0]           sample,
    output logic                               done,
    output logic      [$clog2(TALLY_BINS)-1:0] len,
    output logic      [$clog2(TALLY_BINS)-1:0] longest_next
);

    localparam int AW = $clog2(TALLY_BINS);
    localparam int MW = MAX_COUPONS;
    localparam logic [AW-1:0] LEN_MAX = AW'(TALLY_BINS - 1);

    logic [CC_W-1:0] coupon_count_reg;
    logic [MW-1:0]   map_reg, map_next;
    logic [AW-1:0]   run_reg, run_next;
    logic [AW-1:0]   longest_reg;

    logic [CC_W-1:0]          n_eff;
    logic [SAMPLE_W+CC_W-1:0] product;
    logic [CC_W-1:0]          coupon;
    logic [MW-1:0]            bit_sel;
    logic [MW-1:0]            full_set;
    logic [MW-1:0]            map_or;
    logic [AW-1:0]            run_inc;
    logic                     new_coupon;

    always_comb begin
        priority if (coupon_count_reg < CC_MIN) begin
            n_eff = CC_MIN;
        end else if (32'(coupon_count_reg) > MAX_COUPONS) begin
            n_eff = CC_W'(MAX_COUPONS);
        end else begin
            n_eff = coupon_count_reg;
        end
    end

    // coupon is the integer part of sample * n
    assign product  = (SAMPLE_W+CC_W)'(sample) * (SAMPLE_W+CC_W)'(n_eff);
    assign coupon   = product[SAMPLE_W+CC_W-1:SAMPLE_W];
    assign bit_sel  = MW'(1) << coupon;
    assign full_set = (MW'(1) << n_eff) - MW'(1);
    assign map_or   = map_reg | bit_sel;

    assign new_coupon = (map_reg & bit_sel) == '0;
    assign run_inc    = (run_reg < LEN_MAX) ? run_reg + AW'(1) : run_reg;
    assign done       = new_coupon && (map_or == full_set);
    assign len        = done ? run_inc : '0;

    always_comb begin
        longest_next = longest_reg;
        if (step && done && (run_inc > longest_reg)) begin
            longest_next = run_inc;
        end
    end

    always_comb begin
        map_next = map_reg;
        run_next = run_reg;
        if (cfg_wr_en) begin
            map_next = '0;
            run_next = '0;
        end else if (step) begin
            map_next = done ? '0 : map_or;
            run_next = done ? '0 : run_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coupon_count_reg <= CC_RESET;
            map_reg          <= '0;
            run_reg          <= '0;
            longest_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                coupon_count_reg <= cfg_wr_data;
            end
            map_reg     <= map_next;
            run_reg     <= run_next;
            longest_reg <= longest_next;
        end
    end

endmodule

`default_nettype wire

@@ design/cct_tally.sv @@
// histogram memory with clearing sweep, write bypass and saturating update
`default_nettype none

module cct_tally
    import cct_pkg::*;
#(
    parameter int TALLY_BINS = TALLY_BINS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TALLY_BINS)-1:0] rd_addr,
    input  wire logic                          wr_go,
    output logic      [COUNT_W-1:0]            rd_count,
    output logic                               busy
);

    localparam int AW = $clog2(TALLY_BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(TALLY_BINS - 1);

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      addr_reg;
    logic               byp_hit_reg;
    logic [COUNT_W-1:0] byp_data_reg;
    logic [COUNT_W-1:0] ram_q;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] bumped;

    // bin value as it stands once the write of the same edge lands
    assign rd_count = byp_hit_reg ? byp_data_reg : ram_q;
    assign bumped   = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
    assign busy     = clr_busy_reg;

    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = wr_go;
            ram_waddr = addr_reg;
            ram_wdata = bumped;
        end
    end

    cct_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TALLY_BINS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            byp_hit_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_BIN) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (rd_en) begin
                byp_hit_reg <= wr_go && (addr_reg == rd_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_reg     <= rd_addr;
            byp_data_reg <= bumped;
        end
    end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for the coupon collector tally block
`timescale 1ns / 100ps

module tb;
    import cct_pkg::*;

    // one result beat, field for field as it leaves the block
    typedef struct {
        logic               tuple_done;
        logic [LEN_W-1:0]   tuple_length;
        logic [COUNT_W-1:0] tally_count;
        logic [LEN_W-1:0]   max_length;
    } tally_result_t;

    // shadow copy of the tally state plus the queue of results still owed
    class tally_tracker;
        logic [CC_W-1:0]            coupon_reg;
        logic [MAX_COUPONS_DEF-1:0] seen_map;
        int unsigned                distinct_cnt;
        int unsigned                run_len;
        int unsigned                longest_len;
        logic [COUNT_W-1:0]         len_hist [TALLY_BINS_DEF];
        tally_result_t              awaited[$];
        int unsigned                mismatches;

        function void clear_all();
            coupon_reg   = CC_RESET;
            seen_map     = '0;
            distinct_cnt = 0;
            run_len      = 0;
            longest_len  = 0;
            foreach (len_hist[i]) len_hist[i] = '0;
            awaited.delete();
            mismatches   = 0;
        endfunction

        // a register write drops the tuple in progress, histogram and max stay
        function void write_coupons(logic [CC_W-1:0] value);
            coupon_reg   = value;
            seen_map     = '0;
            distinct_cnt = 0;
            run_len      = 0;
        endfunction

        function void note_beat(kind_t kind, logic [SAMPLE_W-1:0] smp,
                                logic [BIN_W-1:0] bin);
            tally_result_t r;
            int unsigned   n;
            logic [63:0]   prod;
            int unsigned   coupon;
            r.tuple_done   = 1'b0;
            r.tuple_length = '0;
            r.tally_count  = '0;
            if (kind == KIND_READ) begin
                if (int'(bin) < TALLY_BINS_DEF) r.tally_count = len_hist[bin];
            end else begin
                // out-of-range counts clamp to 2..MAX_COUPONS
                n = 32'(coupon_reg);
                if (n < 32'(CC_MIN)) n = 32'(CC_MIN);
                if (n > MAX_COUPONS_DEF) n = MAX_COUPONS_DEF;
                prod   = 64'(smp) * 64'(n);
                coupon = prod[63:32];
                if (run_len < TALLY_BINS_DEF - 1) run_len++;
                if (!seen_map[coupon]) begin
                    seen_map[coupon] = 1'b1;
                    distinct_cnt++;
                    if (distinct_cnt >= n) begin
                        r.tuple_done   = 1'b1;
                        r.tuple_length = LEN_W'(run_len);
                        if (run_len > longest_len) longest_len = run_len;
                        if (len_hist[run_len] != '1) len_hist[run_len]++;
                        seen_map     = '0;
                        distinct_cnt = 0;
                        run_len      = 0;
                    end
                end
            end
            r.max_length = LEN_W'(longest_len);
            awaited.push_back(r);
        endfunction

        function void check_beat(tally_result_t got);
            tally_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result done=%0d len=%0d count=%0d max=%0d",
                             $realtime, got.tuple_done, got.tuple_length,
                             got.tally_count, got.max_length);
                return;
            end
            want = awaited.pop_front();
            if (got.tuple_done !== want.tuple_done || got.tuple_length !== want.tuple_length ||
                got.tally_count !== want.tally_count || got.max_length !== want.max_length) begin
                mismatches++;
                if (mismatches <= 10)
                    $display(
                        "%0t: exp done/len/count/max %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        $realtime, want.tuple_done, want.tuple_length,
                        want.tally_count, want.max_length, got.tuple_done,
                        got.tuple_length, got.tally_count, got.max_length);
            end
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CC_W-1:0]     cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_kind      = KIND_SAMPLE;
    logic [SAMPLE_W-1:0] s_sample    = '0;
    logic [BIN_W-1:0]    s_bin_index = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_tuple_done;
    logic [LEN_W-1:0]    m_tuple_length;
    logic [COUNT_W-1:0]  m_tally_count;
    logic [LEN_W-1:0]    m_max_length;

    tally_tracker tally;

    // sender burst bookkeeping
    int burst_left = 0;

    // receiver stall pattern
    int unsigned rdy_tick = 0;
    int          rdy_mode = 0;

    coupon_collector_tally_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_sample       (s_sample),
        .s_bin_index    (s_bin_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tuple_done   (m_tuple_done),
        .m_tuple_length (m_tuple_length),
        .m_tally_count  (m_tally_count),
        .m_max_length   (m_max_length)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: the stall mode is redrawn at random, from never stalling to mostly stalled
    always @(posedge aclk) begin
        rdy_tick++;
        if (rdy_tick % 250 == 0) rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (rdy_tick % 8) >= 3;
            end
            default: begin
                m_ready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    // result monitor: values seen here are the ones sampled at this edge
    always @(posedge aclk) begin
        tally_result_t beat;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            beat.tuple_done   = m_tuple_done;
            beat.tuple_length = m_tuple_length;
            beat.tally_count  = m_tally_count;
            beat.max_length   = m_max_length;
            tally.check_beat(beat);
        end
    end

    // drive one input beat and hold it until taken; then maybe open a gap
    task automatic put_item(input kind_t kind, input logic [SAMPLE_W-1:0] smp,
                            input logic [BIN_W-1:0] bin);
        int gap;
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_sample    <= smp;
        s_bin_index <= bin;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        tally.note_beat(kind, smp, bin);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // now and then a long stretch without any idling
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
        end
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (tally.awaited.size() != 0) @(posedge aclk);
    endtask

    // register writes only go in while the block is idle
    task automatic set_coupons(input logic [CC_W-1:0] value);
        wait_results_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        tally.write_coupons(value);
        cfg_wr_en   <= 1'b0;
    endtask

    // random traffic: mostly plain samples that complete tuples, some reads and extremes
    task automatic run_phase(input int items);
        int                  roll;
        int                  pick;
        int                  pause_at;
        logic [BIN_W-1:0]    bin;
        logic [SAMPLE_W-1:0] smp;
        pause_at = $urandom_range(0, items - 1);
        for (int i = 0; i < items; i++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            smp  = $urandom;
            bin  = BIN_W'($urandom);
            if (roll < 15) begin
                // reads mostly land on the populated short-length bins
                if (pick < 6) bin = BIN_W'($urandom_range(0, 48));
                else if (pick == 9) bin = '1;
                put_item(KIND_READ, smp, bin);
            end else begin
                if (roll < 19) smp = '0;
                else if (roll < 23) smp = '1;
                put_item(KIND_SAMPLE, smp, bin);
            end
            // idle mid-tuple: the tuple must survive the pause
            if (i == pause_at) wait_results_drained();
        end
    endtask

    initial begin
        int          cfg_plan [10] = '{12, 0, 15, 1, 13, 7, 7, 3, 14, 5};
        logic [63:0] slice_lo;

        tally = new;
        tally.clear_all();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, coupon count at its reset value of two
        // empty histogram at both ends of the bin range
        put_item(KIND_READ, $urandom, '0);
        put_item(KIND_READ, $urandom, '1);
        // repeat of a coupon lengthens the tuple, lowest and highest fractions
        put_item(KIND_SAMPLE, '0, BIN_W'($urandom));
        put_item(KIND_SAMPLE, '0, BIN_W'($urandom));
        put_item(KIND_SAMPLE, '1, BIN_W'($urandom));
        // fractions on either side of the half-way split
        put_item(KIND_SAMPLE, 32'h7FFF_FFFF, BIN_W'($urandom));
        put_item(KIND_SAMPLE, 32'h8000_0000, BIN_W'($urandom));
        put_item(KIND_READ, $urandom, BIN_W'(2));
        put_item(KIND_READ, $urandom, BIN_W'(3));

        // full twelve coupons, each drawn at the lowest fraction of its slice
        set_coupons(CC_W'(MAX_COUPONS_DEF));
        for (int c = 0; c < MAX_COUPONS_DEF; c++) begin
            slice_lo = ((64'(c) << 32) + 64'(MAX_COUPONS_DEF - 1)) / 64'(MAX_COUPONS_DEF);
            put_item(KIND_SAMPLE, slice_lo[31:0], BIN_W'($urandom));
        end
        put_item(KIND_READ, $urandom, BIN_W'(MAX_COUPONS_DEF));

        // random phases over in-range, clamped low and clamped high counts
        foreach (cfg_plan[p]) begin
            set_coupons(CC_W'(cfg_plan[p]));
            run_phase(110);
        end

        // a couple more phases at random counts
        repeat (2) begin
            set_coupons(CC_W'($urandom_range(0, 15)));
            run_phase(110);
        end

        // let the last results drain, then watch for anything stray
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (tally.mismatches == 0 && tally.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run including the reset sweep
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
